>>> rtl/lsr_pkg.sv
package lsr_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int ANG_IN_WIDTH = 15;
    localparam int ANG_IN_FRAC  = 12;
    localparam int GUARD_BITS   = 14;
    localparam int GAIN_SHIFT   = 30 - GUARD_BITS;
    localparam int MAX_STAGES   = 24;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint ATAN_Q30 [0:MAX_STAGES-1] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Q2.30 constant rounded half up to frac fraction bits
    function automatic longint ang_const(input longint q30, input int frac);
        int     s;
        longint v;
        s = 30 - frac;
        v = q30 + (longint'(1) <<< (s - 1));
        return v >>> s;
    endfunction

endpackage

>>> rtl/line_segment_rotate_about_midpoint_unit.sv
// Each CORDIC iteration owns one pipeline stage.
// Throughput: one transaction per cycle while the output is not stalled.
// Stages: align, half-turn pre-rotation, gain multiply, NSTG CORDIC iterations, round/saturate.
// Stalls collapse bubbles; a full pipeline stops as a whole when the output is stalled.
// Reset: synchronous, active low; clears the valid bits only, datapath registers keep content.
module line_segment_rotate_about_midpoint_unit
    import lsr_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]  i_start_x,
    input  logic signed [COORD_WIDTH-1:0]  i_start_y,
    input  logic signed [COORD_WIDTH-1:0]  i_end_x,
    input  logic signed [COORD_WIDTH-1:0]  i_end_y,
    input  logic signed [ANG_IN_WIDTH-1:0] i_turn_angle,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [COORD_WIDTH-1:0]  o_new_start_x,
    output logic signed [COORD_WIDTH-1:0]  o_new_start_y,
    output logic signed [COORD_WIDTH-1:0]  o_new_end_x,
    output logic signed [COORD_WIDTH-1:0]  o_new_end_y,
    output logic                           o_clipped
);

    localparam int SW   = COORD_WIDTH + 1;
    localparam int XW   = COORD_WIDTH + 17;
    localparam int ZW   = ANGLE_WIDTH + 1;
    localparam int FRAC = ANGLE_WIDTH - 4;
    localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    logic                 front_en;
    logic [NSTG:0]        v_c;
    logic [NSTG:0]        en_c;
    logic signed [SW-1:0] sx_c [0:NSTG];
    logic signed [SW-1:0] sy_c [0:NSTG];
    logic signed [XW-1:0] px_c [0:NSTG];
    logic signed [XW-1:0] py_c [0:NSTG];
    logic signed [ZW-1:0] z_c  [0:NSTG-1];

    lsr_front #(
        .W    (COORD_WIDTH),
        .SW   (SW),
        .XW   (XW),
        .ZW   (ZW),
        .FRAC (FRAC)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_turn_angle (i_turn_angle),
        .i_next_en    (en_c[0]),
        .o_en         (front_en),
        .o_valid      (v_c[0]),
        .o_sx         (sx_c[0]),
        .o_sy         (sy_c[0]),
        .o_px         (px_c[0]),
        .o_py         (py_c[0]),
        .o_z          (z_c[0])
    );

    assign o_in_stall = !front_en;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_K = ZW'(ang_const(ATAN_Q30[k], FRAC));
        if (k < NSTG - 1) begin : g_mid
            lsr_cordic_stage #(
                .SW     (SW),
                .XW     (XW),
                .ZW     (ZW),
                .SHIFT  (k),
                .P_ATAN (ATAN_K)
            ) u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (v_c[k]),
                .i_sx      (sx_c[k]),
                .i_sy      (sy_c[k]),
                .i_px      (px_c[k]),
                .i_py      (py_c[k]),
                .i_z       (z_c[k]),
                .i_next_en (en_c[k+1]),
                .o_en      (en_c[k]),
                .o_valid   (v_c[k+1]),
                .o_sx      (sx_c[k+1]),
                .o_sy      (sy_c[k+1]),
                .o_px      (px_c[k+1]),
                .o_py      (py_c[k+1]),
                .o_z       (z_c[k+1])
            );
        end else begin : g_last
            lsr_cordic_stage #(
                .SW     (SW),
                .XW     (XW),
                .ZW     (ZW),
                .SHIFT  (k),
                .P_ATAN (ATAN_K)
            ) u_stage (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_valid   (v_c[k]),
                .i_sx      (sx_c[k]),
                .i_sy      (sy_c[k]),
                .i_px      (px_c[k]),
                .i_py      (py_c[k]),
                .i_z       (z_c[k]),
                .i_next_en (en_c[k+1]),
                .o_en      (en_c[k]),
                .o_valid   (v_c[k+1]),
                .o_sx      (sx_c[k+1]),
                .o_sy      (sy_c[k+1]),
                .o_px      (px_c[k+1]),
                .o_py      (py_c[k+1]),
                .o_z       ()
            );
        end
    end

    lsr_finish #(
        .W  (COORD_WIDTH),
        .SW (SW),
        .XW (XW)
    ) u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (v_c[NSTG]),
        .i_sx          (sx_c[NSTG]),
        .i_sy          (sy_c[NSTG]),
        .i_px          (px_c[NSTG]),
        .i_py          (py_c[NSTG]),
        .i_out_stall   (i_out_stall),
        .o_en          (en_c[NSTG]),
        .o_out_valid   (o_out_valid),
        .o_new_start_x (o_new_start_x),
        .o_new_start_y (o_new_start_y),
        .o_new_end_x   (o_new_end_x),
        .o_new_end_y   (o_new_end_y),
        .o_clipped     (o_clipped)
    );

endmodule

>>> rtl/lsr_front.sv
module lsr_front
    import lsr_pkg::*;
#(
    parameter int W    = COORD_WIDTH_DEF,
    parameter int SW   = COORD_WIDTH_DEF + 1,
    parameter int XW   = COORD_WIDTH_DEF + 17,
    parameter int ZW   = ANGLE_WIDTH_DEF + 1,
    parameter int FRAC = ANGLE_WIDTH_DEF - 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [W-1:0]            i_start_x,
    input  logic signed [W-1:0]            i_start_y,
    input  logic signed [W-1:0]            i_end_x,
    input  logic signed [W-1:0]            i_end_y,
    input  logic signed [ANG_IN_WIDTH-1:0] i_turn_angle,
    input  logic                           i_next_en,
    output logic                           o_en,
    output logic                           o_valid,
    output logic signed [SW-1:0]           o_sx,
    output logic signed [SW-1:0]           o_sy,
    output logic signed [XW-1:0]           o_px,
    output logic signed [XW-1:0]           o_py,
    output logic signed [ZW-1:0]           o_z
);

    localparam int LSH = (FRAC >= ANG_IN_FRAC) ? FRAC - ANG_IN_FRAC : 0;
    localparam int RSH = (FRAC >= ANG_IN_FRAC) ? 0 : ANG_IN_FRAC - FRAC;
    localparam int AW  = ANG_IN_WIDTH + LSH;
    localparam int PW  = XW + GAIN_SHIFT;

    localparam logic signed [ZW-1:0] HALF_PI = ZW'(ang_const(HALF_PI_Q30, FRAC));
    localparam logic signed [ZW-1:0] PI_C    = ZW'(ang_const(PI_Q30, FRAC));
    localparam logic signed [PW-1:0] GAIN_P  = PW'(GAIN_Q30);

    logic en1, en2, en3;

    logic                  r_s1_valid, r_s2_valid, r_s3_valid;
    logic signed [SW-1:0]  r_s1_sx, r_s1_sy, r_s1_dx, r_s1_dy;
    logic signed [ZW-1:0]  r_s1_z;
    logic signed [SW-1:0]  r_s2_sx, r_s2_sy, r_s2_dx, r_s2_dy;
    logic signed [ZW-1:0]  r_s2_z;
    logic signed [SW-1:0]  r_s3_sx, r_s3_sy;
    logic signed [XW-1:0]  r_s3_px, r_s3_py;
    logic signed [ZW-1:0]  r_s3_z;

    logic signed [AW-1:0]  a_wide;
    logic signed [ZW-1:0]  n_s1_z;
    logic signed [SW-1:0]  n_s2_dx, n_s2_dy;
    logic signed [ZW-1:0]  n_s2_z;
    logic signed [PW-1:0]  prod_x, prod_y;

    assign en3  = !r_s3_valid || i_next_en;
    assign en2  = !r_s2_valid || en3;
    assign en1  = !r_s1_valid || en2;
    assign o_en = en1;

    // align Q3.12 input to the internal angle format
    assign a_wide = AW'(i_turn_angle) <<< LSH;
    assign n_s1_z = ZW'(a_wide >>> RSH);

    // half-turn pre-rotation
    always_comb begin
        n_s2_dx = r_s1_dx;
        n_s2_dy = r_s1_dy;
        n_s2_z  = r_s1_z;
        if (r_s1_z > HALF_PI) begin
            n_s2_dx = -r_s1_dx;
            n_s2_dy = -r_s1_dy;
            n_s2_z  = r_s1_z - PI_C;
        end else if (r_s1_z < -HALF_PI) begin
            n_s2_dx = -r_s1_dx;
            n_s2_dy = -r_s1_dy;
            n_s2_z  = r_s1_z + PI_C;
        end
    end

    assign prod_x = PW'(r_s2_dx) * GAIN_P;
    assign prod_y = PW'(r_s2_dy) * GAIN_P;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (en1) r_s1_valid <= i_valid;
            if (en2) r_s2_valid <= r_s1_valid;
            if (en3) r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sx <= SW'(i_start_x) + SW'(i_end_x);
            r_s1_sy <= SW'(i_start_y) + SW'(i_end_y);
            r_s1_dx <= SW'(i_start_x) - SW'(i_end_x);
            r_s1_dy <= SW'(i_start_y) - SW'(i_end_y);
            r_s1_z  <= n_s1_z;
        end
        if (en2) begin
            r_s2_sx <= r_s1_sx;
            r_s2_sy <= r_s1_sy;
            r_s2_dx <= n_s2_dx;
            r_s2_dy <= n_s2_dy;
            r_s2_z  <= n_s2_z;
        end
        if (en3) begin
            r_s3_sx <= r_s2_sx;
            r_s3_sy <= r_s2_sy;
            r_s3_px <= prod_x[PW-1:GAIN_SHIFT];
            r_s3_py <= prod_y[PW-1:GAIN_SHIFT];
            r_s3_z  <= r_s2_z;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_sx    = r_s3_sx;
    assign o_sy    = r_s3_sy;
    assign o_px    = r_s3_px;
    assign o_py    = r_s3_py;
    assign o_z     = r_s3_z;

endmodule

>>> rtl/lsr_cordic_stage.sv
module lsr_cordic_stage
    import lsr_pkg::*;
#(
    parameter int                   SW      = COORD_WIDTH_DEF + 1,
    parameter int                   XW      = COORD_WIDTH_DEF + 17,
    parameter int                   ZW      = ANGLE_WIDTH_DEF + 1,
    parameter int                   SHIFT   = 0,
    parameter logic signed [ZW-1:0] P_ATAN  = '0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [SW-1:0] i_sx,
    input  logic signed [SW-1:0] i_sy,
    input  logic signed [XW-1:0] i_px,
    input  logic signed [XW-1:0] i_py,
    input  logic signed [ZW-1:0] i_z,
    input  logic                 i_next_en,
    output logic                 o_en,
    output logic                 o_valid,
    output logic signed [SW-1:0] o_sx,
    output logic signed [SW-1:0] o_sy,
    output logic signed [XW-1:0] o_px,
    output logic signed [XW-1:0] o_py,
    output logic signed [ZW-1:0] o_z
);

    logic                 en;
    logic                 r_valid;
    logic signed [SW-1:0] r_sx, r_sy;
    logic signed [XW-1:0] r_px, r_py;
    logic signed [ZW-1:0] r_z;
    logic signed [XW-1:0] xs, ys;
    logic signed [XW-1:0] n_px, n_py;
    logic signed [ZW-1:0] n_z;

    assign en   = !r_valid || i_next_en;
    assign o_en = en;

    assign xs = i_px >>> SHIFT;
    assign ys = i_py >>> SHIFT;

    always_comb begin
        if (!i_z[ZW-1]) begin
            n_px = i_px - ys;
            n_py = i_py + xs;
            n_z  = i_z - P_ATAN;
        end else begin
            n_px = i_px + ys;
            n_py = i_py - xs;
            n_z  = i_z + P_ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx <= i_sx;
            r_sy <= i_sy;
            r_px <= n_px;
            r_py <= n_py;
            r_z  <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_px    = r_px;
    assign o_py    = r_py;
    assign o_z     = r_z;

endmodule

>>> rtl/lsr_finish.sv
module lsr_finish
    import lsr_pkg::*;
#(
    parameter int W  = COORD_WIDTH_DEF,
    parameter int SW = COORD_WIDTH_DEF + 1,
    parameter int XW = COORD_WIDTH_DEF + 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [SW-1:0] i_sx,
    input  logic signed [SW-1:0] i_sy,
    input  logic signed [XW-1:0] i_px,
    input  logic signed [XW-1:0] i_py,
    input  logic                 i_out_stall,
    output logic                 o_en,
    output logic                 o_out_valid,
    output logic signed [W-1:0]  o_new_start_x,
    output logic signed [W-1:0]  o_new_start_y,
    output logic signed [W-1:0]  o_new_end_x,
    output logic signed [W-1:0]  o_new_end_y,
    output logic                 o_clipped
);

    localparam int TW = XW + 2;
    localparam logic signed [TW-1:0] RND  = TW'(longint'(1) <<< GUARD_BITS);
    localparam logic signed [TW-1:0] MAXV = TW'((longint'(1) <<< (W - 1)) - 1);
    localparam logic signed [TW-1:0] MINV = TW'(-(longint'(1) <<< (W - 1)));

    // {clip, value}: round to nearest (ties up), saturate
    function automatic logic [W:0] fin(input logic signed [SW-1:0] s,
                                       input logic signed [XW-1:0] r,
                                       input logic                 neg);
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] rr;
        rr = neg ? -TW'(r) : TW'(r);
        t  = (TW'(s) <<< GUARD_BITS) + rr + RND;
        t  = t >>> (GUARD_BITS + 1);
        if (t > MAXV) begin
            return {1'b1, MAXV[W-1:0]};
        end else if (t < MINV) begin
            return {1'b1, MINV[W-1:0]};
        end
        return {1'b0, t[W-1:0]};
    endfunction

    logic         en;
    logic         r_valid;
    logic [W-1:0] r_nsx, r_nsy, r_nex, r_ney;
    logic         r_clip;
    logic [W:0]   n_sx, n_sy, n_ex, n_ey;

    assign en   = !r_valid || !i_out_stall;
    assign o_en = en;

    assign n_sx = fin(i_sx, i_px, 1'b0);
    assign n_sy = fin(i_sy, i_py, 1'b0);
    assign n_ex = fin(i_sx, i_px, 1'b1);
    assign n_ey = fin(i_sy, i_py, 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nsx  <= n_sx[W-1:0];
            r_nsy  <= n_sy[W-1:0];
            r_nex  <= n_ex[W-1:0];
            r_ney  <= n_ey[W-1:0];
            r_clip <= n_sx[W] | n_sy[W] | n_ex[W] | n_ey[W];
        end
    end

    assign o_out_valid   = r_valid;
    assign o_new_start_x = r_nsx;
    assign o_new_start_y = r_nsy;
    assign o_new_end_x   = r_nex;
    assign o_new_end_y   = r_ney;
    assign o_clipped     = r_clip;

endmodule

>>> test/tb_line_segment_rotate_about_midpoint_unit.sv
`timescale 1ns / 100ps

module tb_line_segment_rotate_about_midpoint_unit;
    import lsr_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int AW        = ANG_IN_WIDTH;
    localparam int AFRAC     = ANGLE_WIDTH_DEF - 4;
    localparam int NSTAGES   = (CORDIC_STAGES_DEF > 24) ? 24 : CORDIC_STAGES_DEF;
    localparam int PIPE_LAT  = CORDIC_STAGES_DEF + 4;
    localparam int N_RANDOM  = 450;
    localparam int CYCLE_CAP = 200000;

    localparam longint K_GAIN    = 64'sd652032874;
    localparam longint K_PI      = 64'sd3373259426;
    localparam longint K_HALF_PI = 64'sd1686629713;
    localparam int     FRAC_G    = 14;

    localparam longint ARCTAN_Q30 [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [AW-1:0] ang;
        int                   gap;
        bit                   drain;
    } t_segment;

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic                 clip;
    } t_rotated;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [CW-1:0] i_start_x;
    logic signed [CW-1:0] i_start_y;
    logic signed [CW-1:0] i_end_x;
    logic signed [CW-1:0] i_end_y;
    logic signed [AW-1:0] i_turn_angle;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [CW-1:0] o_new_start_x;
    logic signed [CW-1:0] o_new_start_y;
    logic signed [CW-1:0] o_new_end_x;
    logic signed [CW-1:0] o_new_end_y;
    logic                 o_clipped;

    t_segment pending_segs[$];
    t_rotated rotated_expect[$];
    int       n_total;
    int       n_sent;
    int       n_checked;
    int       n_clipped;
    int       n_errors;
    int       cycles;
    int       in_gap;
    int       stall_left;
    bit       in_fire;
    bit       out_calm;

    line_segment_rotate_about_midpoint_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_turn_angle  (i_turn_angle),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_new_start_x (o_new_start_x),
        .o_new_start_y (o_new_start_y),
        .o_new_end_x   (o_new_end_x),
        .o_new_end_y   (o_new_end_y),
        .o_clipped     (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint angle_units(input longint q30);
        int s;
        s = 30 - AFRAC;
        return (q30 + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [CW-1:0] round_saturate(input longint sum,
                                                            input longint rot,
                                                            inout bit clip);
        longint v;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -(longint'(1) <<< (CW - 1));
        v = ((sum <<< FRAC_G) + rot + (longint'(1) <<< FRAC_G)) >>> (FRAC_G + 1);
        if (v > hi) begin
            v = hi;
            clip = 1'b1;
        end
        if (v < lo) begin
            v = lo;
            clip = 1'b1;
        end
        return v[CW-1:0];
    endfunction

    function automatic t_rotated rotate_about_midpoint(input t_segment s);
        t_rotated r;
        longint   sumx;
        longint   sumy;
        longint   dx;
        longint   dy;
        longint   z;
        longint   px;
        longint   py;
        longint   xs;
        longint   ys;
        longint   t;
        bit       clip;
        sumx = longint'(s.sx) + longint'(s.ex);
        sumy = longint'(s.sy) + longint'(s.ey);
        dx   = longint'(s.sx) - longint'(s.ex);
        dy   = longint'(s.sy) - longint'(s.ey);
        z    = longint'(s.ang);
        if (AFRAC >= ANG_IN_FRAC)
            z = z <<< (AFRAC - ANG_IN_FRAC);
        else
            z = z >>> (ANG_IN_FRAC - AFRAC);
        // fold into the CORDIC convergence range by a half turn
        if (z > angle_units(K_HALF_PI)) begin
            dx = -dx;
            dy = -dy;
            z  = z - angle_units(K_PI);
        end else if (z < -angle_units(K_HALF_PI)) begin
            dx = -dx;
            dy = -dy;
            z  = z + angle_units(K_PI);
        end
        px = (dx * K_GAIN) >>> (30 - FRAC_G);
        py = (dy * K_GAIN) >>> (30 - FRAC_G);
        for (int i = 0; i < NSTAGES; i++) begin
            t  = angle_units(ARCTAN_Q30[i]);
            xs = px >>> i;
            ys = py >>> i;
            if (z >= 0) begin
                px = px - ys;
                py = py + xs;
                z  = z - t;
            end else begin
                px = px + ys;
                py = py - xs;
                z  = z + t;
            end
        end
        clip = 1'b0;
        r.sx = round_saturate(sumx, px, clip);
        r.sy = round_saturate(sumy, py, clip);
        r.ex = round_saturate(sumx, -px, clip);
        r.ey = round_saturate(sumy, -py, clip);
        r.clip = clip;
        return r;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(input int mode);
        int k;
        case (mode)
            0: return CW'(int'($urandom_range(0, 4000)) - 2000);
            1: return CW'($urandom_range(0, 65535));
            2: return CW'(int'($urandom_range(0, 40000)) - 20000);
            default: begin
                k = $urandom_range(0, 15);
                if ($urandom_range(0, 1))
                    return CW'(32767 - k);
                return CW'(-32768 + k);
            end
        endcase
    endfunction

    function automatic logic signed [AW-1:0] pick_angle();
        int r;
        int j;
        r = $urandom_range(0, 99);
        j = int'($urandom_range(0, 6)) - 3;
        if (r < 50)
            return AW'($urandom_range(0, 32767));
        if (r < 80)
            return AW'(int'($urandom_range(0, 25736)) - 12868);
        case ($urandom_range(0, 4))
            0: return AW'(6434 + j);
            1: return AW'(-6434 + j);
            2: return AW'(j);
            3: return AW'(12868 + j);
            default: return AW'(-12868 + j);
        endcase
    endfunction

    task automatic add_segment(input int sx, input int sy, input int ex, input int ey,
                               input int ang, input int gap, input bit drain);
        t_segment s;
        s.sx    = CW'(sx);
        s.sy    = CW'(sy);
        s.ex    = CW'(ex);
        s.ey    = CW'(ey);
        s.ang   = AW'(ang);
        s.gap   = gap;
        s.drain = drain;
        pending_segs.push_back(s);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endtask

    // input side: accept, predict; output side: compare; cycle cap
    always @(posedge i_clk) begin : observe
        t_segment seen;
        t_rotated want;
        cycles++;
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) begin
            seen.sx  = i_start_x;
            seen.sy  = i_start_y;
            seen.ex  = i_end_x;
            seen.ey  = i_end_y;
            seen.ang = i_turn_angle;
            rotated_expect.push_back(rotate_about_midpoint(seen));
            n_sent++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rotated_expect.size() == 0) begin
                $error("unexpected result transaction");
                n_errors++;
            end else begin
                want = rotated_expect.pop_front();
                check_field("new_start_x", want.sx, o_new_start_x);
                check_field("new_start_y", want.sy, o_new_start_y);
                check_field("new_end_x", want.ex, o_new_end_x);
                check_field("new_end_y", want.ey, o_new_end_y);
                check_field("clipped", want.clip, o_clipped);
                n_checked++;
                if (o_clipped === 1'b1)
                    n_clipped++;
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin : drive_in
        t_segment nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // held until taken
        end else if (in_gap > 0) begin
            i_in_valid <= 1'b0;
            in_gap--;
        end else if (pending_segs.size() != 0 &&
                     !(pending_segs[0].drain && rotated_expect.size() != 0)) begin
            nxt = pending_segs.pop_front();
            i_start_x    <= nxt.sx;
            i_start_y    <= nxt.sy;
            i_end_x      <= nxt.ex;
            i_end_y      <= nxt.ey;
            i_turn_angle <= nxt.ang;
            i_in_valid   <= 1'b1;
            in_gap = nxt.gap;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drive_out_stall
        if (cycles % 300 == 0)
            out_calm = ($urandom_range(0, 2) == 0);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap(out_calm);
        end
    end

    initial begin
        t_segment s;
        bit       calm;
        int       mode;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_out_stall  = 1'b0;
        i_start_x    = '0;
        i_start_y    = '0;
        i_end_x      = '0;
        i_end_y      = '0;
        i_turn_angle = '0;
        n_sent       = 0;
        n_checked    = 0;
        n_clipped    = 0;
        n_errors     = 0;
        cycles       = 0;
        in_gap       = 0;
        stall_left   = 0;
        in_fire      = 1'b0;
        out_calm     = 1'b1;
        calm         = 1'b1;

        // directed: extremes, degenerate, half-turn boundaries, saturation
        add_segment(100, 100, 100, 100, 5000, 0, 0);
        add_segment(32767, -32768, 32767, -32768, 8000, 0, 0);
        add_segment(1000, -500, -1200, 700, 0, 0, 0);
        add_segment(32767, 32767, 32767, 32767, 0, 1, 0);
        add_segment(-32768, -32768, -32768, -32768, 0, 0, 0);
        add_segment(32767, -32768, -32768, 32767, 3217, 0, 0);
        add_segment(-32768, 32767, 32767, -32768, -3217, 2, 0);
        add_segment(32000, 32000, -32000, -32000, 3217, 0, 0);
        add_segment(30000, 0, -30000, 0, 6434, 0, 0);
        add_segment(1500, 200, -700, -900, 12868, 0, 0);
        add_segment(1500, 200, -700, -900, -12868, 0, 0);
        add_segment(-400, 800, 1200, -300, 16383, 0, 0);
        add_segment(-400, 800, 1200, -300, -16384, 3, 0);
        add_segment(640, -640, -320, 960, 6434, 0, 0);
        add_segment(640, -640, -320, 960, 6435, 0, 0);
        add_segment(640, -640, -320, 960, -6434, 0, 0);
        add_segment(640, -640, -320, 960, -6435, 0, 0);
        add_segment(5000, 7000, -3000, 2000, 1, 0, 0);
        add_segment(5000, 7000, -3000, 2000, -1, 0, 0);
        add_segment(1, 0, 0, 0, 6434, 0, 0);
        add_segment(-1, -1, 0, 0, 12868, 0, 0);
        add_segment(32767, 0, -32768, 0, 6434, 0, 0);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 99);
            if (mode < 45)
                mode = 0;
            else if (mode < 65)
                mode = 1;
            else if (mode < 80)
                mode = 2;
            else if (mode < 88)
                mode = 4;
            else
                mode = 3;
            s.sx = pick_coord(mode == 4 ? 1 : mode);
            s.sy = pick_coord(mode == 4 ? 1 : mode);
            s.ex = (mode == 4) ? s.sx : pick_coord(mode);
            s.ey = (mode == 4) ? s.sy : pick_coord(mode);
            s.ang   = pick_angle();
            s.gap   = pick_gap(calm);
            s.drain = (k % 150 == 0);
            pending_segs.push_back(s);
        end
        n_total = pending_segs.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge i_clk);
        while (rotated_expect.size() != 0)
            @(posedge i_clk);
        repeat (2 * PIPE_LAT) @(posedge i_clk);

        $display("%0d segments rotated over %0d cycles, %0d results compared", n_sent,
                 cycles, n_checked);
        $display("%0d results saturated, angles spanned the full 15-bit range", n_clipped);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
